// File: src/mqs_pkg.sv
// Shared types, codes and defaults of the multilevel queue scheduler.
`default_nettype none
package mqs_pkg;

    localparam int NUM_LEVELS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF  = 8;
    localparam int TRACKED_IDS_DEF = 1024;

    // Width of a saturated level number carried between front and back.
    localparam int LVL_W = 8;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_PUT = 2'd1;
    localparam logic [1:0] MODE_GET = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] proc_id;
        logic [3:0]  priority_req;
        logic [31:0] now;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] chosen_id;
        logic [3:0]  chosen_priority;
        logic        all_empty;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [11:0]      proc_id;
        logic [LVL_W-1:0] lvl;
        logic [31:0]      now;
    } cmd_t;

endpackage
`default_nettype wire

// File: src/mqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: src/mqs_front.sv
// Front end: accepts beats, saturates the level and queues commands.
`default_nettype none
module mqs_front #(
    parameter int NUM_LEVELS = mqs_pkg::NUM_LEVELS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               hold,
    input  wire               s_valid,
    output logic              s_ready,
    input  mqs_pkg::in_beat_t s_data,
    output logic              cmd_valid,
    input  wire               cmd_ready,
    output mqs_pkg::cmd_t     cmd
);
    import mqs_pkg::*;

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    cmd_t       cls;
    logic       push;
    logic       pop;

    // Levels past the last one fold onto the last one.
    always_comb begin
        cls.mode    = s_data.mode;
        cls.proc_id = s_data.proc_id;
        cls.now     = s_data.now;
        if ({4'd0, s_data.priority_req} >= LVL_W'(NUM_LEVELS)) begin
            cls.lvl = LVL_W'(NUM_LEVELS - 1);
        end else begin
            cls.lvl = {4'd0, s_data.priority_req};
        end
    end

    assign s_ready   = !hold && (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// File: src/mqs_back.sv
// Back end: level queues, budgets, dispatch-time table and result register.
`default_nettype none
module mqs_back #(
    parameter int NUM_LEVELS  = mqs_pkg::NUM_LEVELS_DEF,
    parameter int FIFO_DEPTH  = mqs_pkg::FIFO_DEPTH_DEF,
    parameter int TRACKED_IDS = mqs_pkg::TRACKED_IDS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    output logic               clearing,
    input  wire                cmd_valid,
    output logic               cmd_ready,
    input  mqs_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  wire                m_ready,
    output mqs_pkg::out_beat_t m_data
);
    import mqs_pkg::*;

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int HW = $clog2(FIFO_DEPTH);
    localparam int AW = $clog2(NUM_LEVELS * FIFO_DEPTH);
    localparam int TW = $clog2(TRACKED_IDS);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg  [NUM_LEVELS];
    logic [HW-1:0]       head_reg   [NUM_LEVELS];
    logic signed [31:0]  budget_reg [NUM_LEVELS];
    cmd_t                cur_reg;
    logic                full_reg;
    logic                tracked_reg;
    logic                none_reg;
    logic [LW-1:0]       found_reg;
    logic [TW-1:0]       clr_reg;
    logic                out_valid_reg;
    out_beat_t           out_reg;

    logic [LW-1:0]       lvl;
    logic [CW-1:0]       lvl_count;
    logic                lvl_full;
    logic [CW:0]         pos_sum;
    logic [HW-1:0]       pos;
    logic [NUM_LEVELS-1:0] refill;
    logic                any_ready;
    logic                any_busy;
    logic [LW-1:0]       ready_idx;
    logic [LW-1:0]       busy_idx;
    logic [LW-1:0]       found;
    logic [HW-1:0]       head_next;
    logic                fire;
    logic [31:0]         dt_rdata;
    logic [11:0]         fifo_rdata;
    logic                cid_tracked;
    logic [31:0]         ticks;
    logic signed [33:0]  diff;
    logic [31:0]         charged;
    logic                empty_all;
    logic                fifo_we;
    logic [AW-1:0]       fifo_waddr;
    logic                fifo_re;
    logic [AW-1:0]       fifo_raddr;
    logic                dt_we;
    logic [TW-1:0]       dt_waddr;
    logic [31:0]         dt_wdata;
    logic                dt_re;

    assign lvl       = LW'(cur_reg.lvl);
    assign lvl_count = count_reg[lvl];
    assign lvl_full  = (lvl_count >= CW'(FIFO_DEPTH));
    always_comb begin
        pos_sum = (CW+1)'(head_reg[lvl]) + (CW+1)'(lvl_count);
        if (pos_sum >= (CW+1)'(FIFO_DEPTH)) begin
            pos = HW'(pos_sum - (CW+1)'(FIFO_DEPTH));
        end else begin
            pos = HW'(pos_sum);
        end
    end

    // Priority scan: exhausted non-empty levels before any funded one refill.
    always_comb begin
        any_ready = 1'b0;
        any_busy  = 1'b0;
        ready_idx = '0;
        busy_idx  = '0;
        refill    = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                if (!any_busy) begin
                    busy_idx = LW'(i);
                end
                any_busy = 1'b1;
                if (!any_ready) begin
                    if (!budget_reg[i][31] && budget_reg[i] != 32'sd0) begin
                        any_ready = 1'b1;
                        ready_idx = LW'(i);
                    end else begin
                        refill[i] = 1'b1;
                    end
                end
            end
        end
        found = any_ready ? ready_idx : busy_idx;
    end

    always_comb begin
        if (head_reg[found] == HW'(FIFO_DEPTH - 1)) begin
            head_next = '0;
        end else begin
            head_next = head_reg[found] + HW'(1);
        end
    end

    assign fire        = (state_reg == ST_FIN) && (!out_valid_reg || m_ready);
    assign cid_tracked = ({1'b0, fifo_rdata} < 13'(TRACKED_IDS));

    always_comb begin
        if (tracked_reg && (cur_reg.now >= dt_rdata)) begin
            ticks = cur_reg.now - dt_rdata;
        end else begin
            ticks = 32'd1;
        end
        diff = $signed({{2{budget_reg[lvl][31]}}, budget_reg[lvl]}) - $signed({2'b00, ticks});
        if (diff[33] && (diff[32:31] != 2'b11)) begin
            charged = 32'h8000_0000;
        end else begin
            charged = diff[31:0];
        end
    end

    always_comb begin
        empty_all = 1'b1;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                empty_all = 1'b0;
            end
        end
    end

    assign fifo_we    = (state_reg == ST_EXEC) && !lvl_full &&
                        (cur_reg.mode == MODE_ADD || cur_reg.mode == MODE_PUT);
    assign fifo_waddr = AW'(32'(lvl) * FIFO_DEPTH + 32'(pos));
    assign fifo_re    = (state_reg == ST_EXEC) && (cur_reg.mode == MODE_GET) && any_busy;
    assign fifo_raddr = AW'(32'(found) * FIFO_DEPTH + 32'(head_reg[found]));

    assign dt_re    = (state_reg == ST_EXEC) && (cur_reg.mode == MODE_PUT);
    assign dt_we    = (state_reg == ST_CLEAR) ||
                      (fire && cur_reg.mode == MODE_GET && !none_reg && cid_tracked);
    assign dt_waddr = (state_reg == ST_CLEAR) ? clr_reg : fifo_rdata[TW-1:0];
    assign dt_wdata = (state_reg == ST_CLEAR) ? 32'd0 : cur_reg.now;

    mqs_ram #(.WIDTH(12), .DEPTH(NUM_LEVELS * FIFO_DEPTH)) u_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (cur_reg.proc_id),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    mqs_ram #(.WIDTH(32), .DEPTH(TRACKED_IDS)) u_time_ram (
        .aclk  (aclk),
        .we    (dt_we),
        .waddr (dt_waddr),
        .wdata (dt_wdata),
        .re    (dt_re),
        .raddr (cur_reg.proc_id[TW-1:0]),
        .rdata (dt_rdata)
    );

    assign clearing  = (state_reg == ST_CLEAR);
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                count_reg[i]  <= '0;
                head_reg[i]   <= '0;
                budget_reg[i] <= 32'(NUM_LEVELS - i);
            end
        end else begin
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + TW'(1);
                    if (clr_reg == TW'(TRACKED_IDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg   <= cmd;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    full_reg    <= lvl_full;
                    tracked_reg <= ({1'b0, cur_reg.proc_id} < 13'(TRACKED_IDS));
                    none_reg    <= !any_busy;
                    found_reg   <= found;
                    if (fifo_we) begin
                        count_reg[lvl] <= lvl_count + CW'(1);
                    end
                    if (cur_reg.mode == MODE_GET) begin
                        for (int i = 0; i < NUM_LEVELS; i++) begin
                            if (refill[i] && any_ready) begin
                                budget_reg[i] <= 32'(NUM_LEVELS - i);
                            end else if (refill[i] || (!any_ready && count_reg[i] != '0 &&
                                         (budget_reg[i][31] || budget_reg[i] == 32'sd0))) begin
                                budget_reg[i] <= 32'(NUM_LEVELS - i);
                            end
                        end
                        if (any_busy) begin
                            head_reg[found]  <= head_next;
                            count_reg[found] <= count_reg[found] - CW'(1);
                        end
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (fire) begin
                        out_reg.status          <= STATUS_OK;
                        out_reg.chosen_id       <= '0;
                        out_reg.chosen_priority <= '0;
                        out_reg.all_empty       <= empty_all;
                        if (cur_reg.mode == MODE_ADD || cur_reg.mode == MODE_PUT) begin
                            if (full_reg) begin
                                out_reg.status <= STATUS_FULL;
                            end else if (cur_reg.mode == MODE_PUT) begin
                                budget_reg[lvl] <= charged;
                            end
                        end else if (cur_reg.mode == MODE_GET) begin
                            if (none_reg) begin
                                out_reg.status <= STATUS_EMPTY;
                            end else begin
                                out_reg.chosen_id       <= fifo_rdata;
                                out_reg.chosen_priority <= 4'((LW+4)'(found_reg));
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/multilevel_queue_scheduler_unit.sv
// Top level of the multilevel queue scheduler: front end, command queue, back end.
// A beat is queued in the front end, latched by the back end, executed and registered onto m_data.
// The back end runs one command at a time; finishing waits while m_data is still held.
// Reset: synchronous, active low; then a clearing pass over all TRACKED_IDS entries zeroes
// the dispatch-time table, during which s_ready stays low.
`default_nettype none
module multilevel_queue_scheduler_unit #(
    parameter int NUM_LEVELS  = mqs_pkg::NUM_LEVELS_DEF,
    parameter int FIFO_DEPTH  = mqs_pkg::FIFO_DEPTH_DEF,
    parameter int TRACKED_IDS = mqs_pkg::TRACKED_IDS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  mqs_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output mqs_pkg::out_beat_t m_data
);
    import mqs_pkg::*;

    // The front classifies each beat and holds up to two commands, so the
    // source can keep going while the back end works or the sink stalls.
    logic clearing;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    mqs_front #(.NUM_LEVELS(NUM_LEVELS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (clearing),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The back end runs one command at a time and owns all scheduler state.
    mqs_back #(
        .NUM_LEVELS  (NUM_LEVELS),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .TRACKED_IDS (TRACKED_IDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // No beat is taken while the dispatch-time table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("input accepted during clearing pass");

    // An empty get reports no id and no level.
    a_empty_get_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_EMPTY) |->
        (m_data.chosen_id == 12'd0 && m_data.chosen_priority == 4'd0))
        else $error("empty get carries an id");

    // An empty get can only happen when every level is empty.
    a_empty_get_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_EMPTY) |-> m_data.all_empty)
        else $error("empty get with a level still occupied");

    // The back end takes one command and is busy in the next cycle.
    a_back_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("back end took two commands back to back");

endmodule
`default_nettype wire

// File: test/tb_multilevel_queue_scheduler_unit.sv
// Self-checking testbench for the multilevel queue scheduler with a built-in scoreboard.
`timescale 1ns / 1ps
module tb_multilevel_queue_scheduler_unit;
    import mqs_pkg::*;

    localparam int LEVELS  = NUM_LEVELS_DEF;
    localparam int DEPTH   = FIFO_DEPTH_DEF;
    localparam int TRACKED = TRACKED_IDS_DEF;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    multilevel_queue_scheduler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // Shadow of the scheduler state: per-level ring buffers, budgets and
    // the per-id dispatch timestamps.
    logic [11:0]        shadow_ids [LEVELS][DEPTH];
    int unsigned        shadow_cnt [LEVELS];
    int unsigned        shadow_head[LEVELS];
    logic signed [31:0] shadow_budget[LEVELS];
    logic [31:0]        shadow_stamp[TRACKED];

    in_beat_t  pending_beats[$];
    out_beat_t expected_results[$];
    int        fail_count = 0;
    bit        stim_done = 1'b0;
    bit        quiet_phase = 1'b0;
    bit        s_ready_seen = 1'b0;

    function automatic bit levels_empty();
        foreach (shadow_cnt[i]) if (shadow_cnt[i] != 0) return 1'b0;
        return 1'b1;
    endfunction

    // Computes the result of one accepted beat and advances the shadow state.
    function automatic out_beat_t schedule_step(in_beat_t b);
        out_beat_t r;
        int unsigned lvl;
        int found;
        longint nb;
        logic [31:0] ticks;
        r = '0;
        lvl = (b.priority_req >= LEVELS) ? LEVELS - 1 : b.priority_req;
        if (b.mode == MODE_ADD || b.mode == MODE_PUT) begin
            if (shadow_cnt[lvl] >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                shadow_ids[lvl][(shadow_head[lvl] + shadow_cnt[lvl]) % DEPTH] = b.proc_id;
                shadow_cnt[lvl]++;
                if (b.mode == MODE_PUT) begin
                    ticks = 32'd1;
                    if (b.proc_id < TRACKED && b.now >= shadow_stamp[b.proc_id])
                        ticks = b.now - shadow_stamp[b.proc_id];
                    nb = longint'(shadow_budget[lvl]) - longint'(ticks);
                    if (nb < -64'sd2147483648) nb = -64'sd2147483648;
                    shadow_budget[lvl] = nb[31:0];
                end
            end
        end else if (b.mode == MODE_GET) begin
            found = -1;
            for (int i = 0; i < LEVELS; i++) begin
                if (shadow_cnt[i] == 0) continue;
                if (shadow_budget[i] > 0) begin
                    found = i;
                    break;
                end
                // Exhausted non-empty levels get a fresh budget as the scan passes.
                shadow_budget[i] = LEVELS - i;
            end
            if (found < 0)
                for (int i = 0; i < LEVELS; i++)
                    if (shadow_cnt[i] != 0) begin
                        found = i;
                        break;
                    end
            if (found < 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.chosen_id = shadow_ids[found][shadow_head[found]];
                shadow_head[found] = (shadow_head[found] + 1) % DEPTH;
                shadow_cnt[found]--;
                r.chosen_priority = found[3:0];
                if (r.chosen_id < TRACKED) shadow_stamp[r.chosen_id] = b.now;
            end
        end
        r.all_empty = levels_empty();
        return r;
    endfunction

    function automatic in_beat_t make_beat(logic [1:0] m, logic [11:0] id,
                                           logic [3:0] p, logic [31:0] t);
        in_beat_t b;
        b.mode = m;
        b.proc_id = id;
        b.priority_req = p;
        b.now = t;
        return b;
    endfunction

    // Driver: presents beats at the falling edge; valid holds until accepted.
    // A stretch in the middle of the random part runs with no idling.
    always @(negedge aclk) begin
        if (aresetn) begin
            quiet_phase = (pending_beats.size() >= 500) && (pending_beats.size() < 900);
            if (!s_valid || s_ready_seen) begin
                if (pending_beats.size() != 0 &&
                    (quiet_phase || $urandom_range(99) >= 35)) begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet_phase || ($urandom_range(99) >= 35);
        end
    end

    // Acceptance is recorded at the rising edge so the driver knows the beat
    // has gone; the prediction runs in the same place.
    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(schedule_step(s_data));
        end
    end

    // Monitor: compares every result beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, m_data);
                fail_count++;
            end else begin
                out_beat_t e;
                e = expected_results.pop_front();
                if (m_data.status !== e.status || m_data.chosen_id !== e.chosen_id ||
                    m_data.chosen_priority !== e.chosen_priority ||
                    m_data.all_empty !== e.all_empty) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, m_data);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [31:0] clock_ticks;
        foreach (shadow_cnt[i]) begin
            shadow_cnt[i] = 0;
            shadow_head[i] = 0;
            shadow_budget[i] = LEVELS - i;
        end
        foreach (shadow_stamp[i]) shadow_stamp[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed part: empty get, spare mode, field extremes, a full level,
        // untracked ids, time running backwards and the budget floor.
        pending_beats.push_back(make_beat(MODE_GET, 12'hfff, 4'hf, 32'd5));
        pending_beats.push_back(make_beat(MODE_SPARE, 12'hfff, 4'hf, 32'hffffffff));
        for (int i = 0; i < DEPTH + 1; i++)
            pending_beats.push_back(make_beat(MODE_ADD, 12'(i * 3 + 1), 4'd0, 32'd0));
        pending_beats.push_back(make_beat(MODE_ADD, 12'hfff, 4'hf, 32'd0));
        pending_beats.push_back(make_beat(MODE_GET, 12'd0, 4'd0, 32'd100));
        pending_beats.push_back(make_beat(MODE_PUT, 12'd1, 4'd0, 32'hffffffff));
        pending_beats.push_back(make_beat(MODE_PUT, 12'd1, 4'd0, 32'hffffffff));
        pending_beats.push_back(make_beat(MODE_GET, 12'd0, 4'd0, 32'd7));
        pending_beats.push_back(make_beat(MODE_GET, 12'd0, 4'd0, 32'd8));
        pending_beats.push_back(make_beat(MODE_PUT, 12'd4, 4'd3, 32'd2));
        pending_beats.push_back(make_beat(MODE_PUT, 12'hfff, 4'd7, 32'd50));
        pending_beats.push_back(make_beat(MODE_PUT, 12'd1023, 4'd9, 32'd0));
        pending_beats.push_back(make_beat(MODE_GET, 12'd0, 4'd0, 32'd9));

        // Random part: small id pool so puts hit tracked stamps, mostly
        // increasing time with occasional jumps to a random value.
        clock_ticks = 32'd1000;
        for (int n = 0; n < 1800; n++) begin
            logic [1:0] m;
            logic [11:0] id;
            int unsigned r;
            r = $urandom_range(99);
            m = (r < 30) ? MODE_ADD : (r < 55) ? MODE_PUT : (r < 97) ? MODE_GET : MODE_SPARE;
            id = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(31));
            if ($urandom_range(19) == 0) clock_ticks = $urandom;
            else clock_ticks += $urandom_range(40);
            pending_beats.push_back(make_beat(m, id,
                ($urandom_range(1) == 0) ? 4'($urandom_range(3)) : 4'($urandom), clock_ticks));
        end

        wait (pending_beats.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: files.f
src/mqs_pkg.sv
src/mqs_ram.sv
src/mqs_front.sv
src/mqs_back.sv
src/multilevel_queue_scheduler_unit.sv
test/tb_multilevel_queue_scheduler_unit.sv
